// File: sv/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared constants, control structs and a helper function of the TS packetizer.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam logic [7:0]  TS_SIZE       = 8'd188;
    localparam logic [7:0]  TS_SYNC       = 8'h47;
    localparam logic [32:0] DEFAULT_DELAY = 33'd63000;
    localparam logic [15:0] PES_LEN_MAX   = 16'hFFFF;
    localparam logic [7:0]  AF_FLAGS_PCR  = 8'h50;
    localparam logic [7:0]  PCR_EXT_LOW   = 8'h7E;
    localparam logic [7:0]  STUFF_BYTE    = 8'hFF;
    localparam logic [7:0]  PES_MARKER    = 8'h80;
    localparam logic [7:0]  PES_PTS_DTS   = 8'hC0;
    localparam logic [3:0]  WORD_BYTES    = 4'd8;
    localparam logic [3:0]  STAMP_PTS     = 4'd2;
    localparam logic [3:0]  STAMP_BOTH    = 4'd3;
    localparam logic [3:0]  STAMP_DTS     = 4'd1;

    // Input item commands.
    localparam logic        CMD_START     = 1'b0;
    localparam logic        CMD_BYTE      = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch frame header fields
        logic latch;     // hold the incoming payload byte
        logic setup;     // prepare the packet header
        logic push_hdr;  // push one header or stuffing byte
        logic push_in;   // push the incoming payload byte
        logic push_held; // push the held payload byte
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_frame;
        logic offset_zero;
        logic hdr_last;
        logic can_push;
    } t_ctrl_status;

    // One byte of a 5-byte PES timestamp field.
    function automatic logic [7:0] stamp_byte(input logic [3:0] prefix,
                                              input logic [32:0] t,
                                              input logic [4:0] k);
        logic [7:0] b;
        case (k)
            5'd0:    b = {prefix, t[32:30], 1'b1};
            5'd1:    b = t[29:22];
            5'd2:    b = {t[21:15], 1'b1};
            5'd3:    b = t[14:7];
            5'd4:    b = {t[6:0], 1'b1};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/ts_pes_packetizer_top.sv
// ----------------------------------------------------------------------------
// ts_pes_packetizer_top
// Cuts elementary-stream frames into 188-byte transport packets.
// ----------------------------------------------------------------------------
// A start item (tuser 0) latches the frame fields. Payload items (tuser 1)
// are taken one per cycle while the output word register can drain. The
// payload byte that opens a packet holds off the input through the setup
// state, the header and stuffing bytes (4 to 187 of them) and the push of
// the held byte, and through any output stall; the header byte sequencer
// pushes one byte per cycle into the word packer while the output can drain.
// Output words carry 8 bytes, 4 on a packet's last word (tlast); tuser marks
// a frame's end.
module ts_pes_packetizer_top #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [32:0]          i_cfg_data,   // presentation_delay
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // payload_byte, pid, stream_id, pts, dts, key_frame, payload_length,
    // continuity_start, zero fill
    input  logic [((100+LENGTH_BITS+7)/8)*8-1:0] s_tdata,
    input  logic [0:0]           s_tuser,      // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,      // data_word, byte_count, continuity
    output logic                 m_tlast,      // packet_end
    output logic [0:0]           m_tuser       // frame_end
);

    localparam int LO_LEN = 96;
    localparam int LO_CS  = 96 + LENGTH_BITS;

    tsp_pkg::t_ctrl_cmd    w_cmd;
    tsp_pkg::t_ctrl_status w_status;
    logic [63:0]           w_word;
    logic [3:0]            w_count, w_cont;

    assign o_cfg_ready = 1'b1;

    tsp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_command (s_tuser[0]),
        .o_in_ready   (s_tready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    tsp_datapath #(.LENGTH_BITS(LENGTH_BITS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .i_payload_byte     (s_tdata[7:0]),
        .i_pid              (s_tdata[20:8]),
        .i_stream_id        (s_tdata[28:21]),
        .i_pts              (s_tdata[61:29]),
        .i_dts              (s_tdata[94:62]),
        .i_key_frame        (s_tdata[95]),
        .i_payload_length   (s_tdata[LO_CS-1:LO_LEN]),
        .i_continuity_start (s_tdata[LO_CS+3:LO_CS]),
        .o_out_valid        (m_tvalid),
        .i_out_ready        (m_tready),
        .o_data_word        (w_word),
        .o_byte_count       (w_count),
        .o_packet_end       (m_tlast),
        .o_frame_end        (m_tuser[0]),
        .o_continuity       (w_cont)
    );

    assign m_tdata = {w_cont, w_count, w_word};

    // Words are full except the short last word of a packet.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (w_count == 4'd8 || w_count == 4'd4))
        else $error("byte count out of range");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tlast == (w_count == 4'd4)))
        else $error("packet end does not match short word");

    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("frame end off a packet end");

    a_short_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tlast) |-> (w_word[31:0] == 32'd0))
        else $error("short word has nonzero tail");

endmodule

// File: sv/tsp_ctrl.sv
// ----------------------------------------------------------------------------
// tsp_ctrl
// Sequencer: accepts items, runs the header pass at each packet start.
// ----------------------------------------------------------------------------
module tsp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_command,
    output logic                  o_in_ready,
    input  tsp_pkg::t_ctrl_status i_status,
    output tsp_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [1:0] {ST_WAIT, ST_SETUP, ST_HDR, ST_BYTE} t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_WAIT) && i_status.can_push;
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_WAIT: begin
                if (w_accept) begin
                    if (i_in_command == tsp_pkg::CMD_START) begin
                        o_cmd.start = 1'b1;
                    end else if (i_status.in_frame) begin
                        if (i_status.offset_zero) begin
                            o_cmd.latch = 1'b1;
                            n_state     = ST_SETUP;
                        end else begin
                            o_cmd.push_in = 1'b1;
                        end
                    end
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_HDR;
            end
            ST_HDR: begin
                if (i_status.can_push) begin
                    o_cmd.push_hdr = 1'b1;
                    if (i_status.hdr_last) begin
                        n_state = ST_BYTE;
                    end
                end
            end
            ST_BYTE: begin
                if (i_status.can_push) begin
                    o_cmd.push_held = 1'b1;
                    n_state         = ST_WAIT;
                end
            end
            default: n_state = ST_WAIT;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/tsp_datapath.sv
// ----------------------------------------------------------------------------
// tsp_datapath
// Frame registers, header byte generator, word packer and output register.
// ----------------------------------------------------------------------------
module tsp_datapath #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tsp_pkg::t_ctrl_cmd     i_cmd,
    output tsp_pkg::t_ctrl_status  o_status,
    input  logic                   i_cfg_valid,
    input  logic [32:0]            i_cfg_data,
    input  logic [7:0]             i_payload_byte,
    input  logic [12:0]            i_pid,
    input  logic [7:0]             i_stream_id,
    input  logic [32:0]            i_pts,
    input  logic [32:0]            i_dts,
    input  logic                   i_key_frame,
    input  logic [LENGTH_BITS-1:0] i_payload_length,
    input  logic [3:0]             i_continuity_start,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [63:0]            o_data_word,
    output logic [3:0]             o_byte_count,
    output logic                   o_packet_end,
    output logic                   o_frame_end,
    output logic [3:0]             o_continuity
);

    localparam int PW = LENGTH_BITS + 1;

    logic [32:0]            r_delay;
    logic [12:0]            r_pid;
    logic [7:0]             r_sid;
    logic [32:0]            r_pts, r_dts;
    logic                   r_key;
    logic [LENGTH_BITS-1:0] r_rem;
    logic [3:0]             r_cc;
    logic                   r_first, r_in_frame;
    logic [7:0]             r_off;
    logic [63:0]            r_acc;
    logic [2:0]             r_fill;
    logic [7:0]             r_byte;
    logic [7:0]             r_hidx, r_aend, r_hend, r_stuff;
    logic                   r_hfirst, r_hadapt, r_two;
    logic [15:0]            r_plen;
    logic [32:0]            r_pcr, r_spts, r_sdts;

    // Setup values for the next packet header.
    logic                   w_two, w_adapt;
    logic [7:0]             w_hsize, w_hlen, w_body, w_stuff, w_aend, w_hend;
    logic [PW-1:0]          w_plen;

    always_comb begin
        w_two   = (r_dts != r_pts);
        w_adapt = r_first && r_key;
        w_hsize = w_two ? 8'd10 : 8'd5;
        w_hlen  = 8'd4 + (w_adapt ? 8'd8 : 8'd0) + (r_first ? 8'd9 + w_hsize : 8'd0);
        w_body  = tsp_pkg::TS_SIZE - w_hlen;
        if (r_rem < LENGTH_BITS'(w_body)) begin
            w_stuff = w_body - r_rem[7:0];
        end else begin
            w_stuff = 8'd0;
        end
        w_aend = (w_adapt ? 8'd12 : 8'd4) + w_stuff;
        w_hend = w_aend + (r_first ? 8'd9 + w_hsize : 8'd0) - 8'd1;
        w_plen = PW'(r_rem) + PW'(w_hsize) + PW'(3);
    end

    // Header byte at the current header index.
    logic [7:0] w_off, w_q, w_hbyte;

    always_comb begin
        w_off = r_hidx - 8'd4;
        w_q   = r_hidx - r_aend;
        if (r_hidx < 8'd4) begin
            case (r_hidx[1:0])
                2'd0: w_hbyte = tsp_pkg::TS_SYNC;
                2'd1: w_hbyte = {1'b0, r_hfirst, 1'b0, r_pid[12:8]};
                2'd2: w_hbyte = r_pid[7:0];
                default: w_hbyte = {2'b00, r_hadapt || (r_stuff != 8'd0), 1'b1, r_cc};
            endcase
        end else if (r_hidx < r_aend) begin
            if (r_hadapt) begin
                case (w_off)
                    8'd0:    w_hbyte = 8'd7 + r_stuff;
                    8'd1:    w_hbyte = tsp_pkg::AF_FLAGS_PCR;
                    8'd2:    w_hbyte = r_pcr[32:25];
                    8'd3:    w_hbyte = r_pcr[24:17];
                    8'd4:    w_hbyte = r_pcr[16:9];
                    8'd5:    w_hbyte = r_pcr[8:1];
                    8'd6:    w_hbyte = {r_pcr[0], tsp_pkg::PCR_EXT_LOW[6:0]};
                    8'd7:    w_hbyte = 8'h00;
                    default: w_hbyte = tsp_pkg::STUFF_BYTE;
                endcase
            end else begin
                case (w_off)
                    8'd0:    w_hbyte = r_stuff - 8'd1;
                    8'd1:    w_hbyte = 8'h00;
                    default: w_hbyte = tsp_pkg::STUFF_BYTE;
                endcase
            end
        end else begin
            case (w_q)
                8'd0, 8'd1: w_hbyte = 8'h00;
                8'd2:       w_hbyte = 8'h01;
                8'd3:       w_hbyte = r_sid;
                8'd4:       w_hbyte = r_plen[15:8];
                8'd5:       w_hbyte = r_plen[7:0];
                8'd6:       w_hbyte = tsp_pkg::PES_MARKER;
                8'd7:       w_hbyte = r_two ? tsp_pkg::PES_PTS_DTS : tsp_pkg::PES_MARKER;
                8'd8:       w_hbyte = r_two ? 8'd10 : 8'd5;
                default: begin
                    if (w_q < 8'd14) begin
                        w_hbyte = tsp_pkg::stamp_byte(
                            r_two ? tsp_pkg::STAMP_BOTH : tsp_pkg::STAMP_PTS,
                            r_spts, 5'(w_q - 8'd9));
                    end else begin
                        w_hbyte = tsp_pkg::stamp_byte(tsp_pkg::STAMP_DTS, r_sdts,
                                                      5'(w_q - 8'd14));
                    end
                end
            endcase
        end
    end

    // Byte push into the word packer.
    logic                   w_push, w_payload, w_emit, w_pend, w_last;
    logic [7:0]             w_pbyte, w_off_new;
    logic [3:0]             w_fill_new;
    logic [63:0]            w_acc_new;
    logic [LENGTH_BITS-1:0] w_rem_new;

    always_comb begin
        w_payload  = i_cmd.push_in || i_cmd.push_held;
        w_push     = w_payload || i_cmd.push_hdr;
        w_pbyte    = i_cmd.push_in ? i_payload_byte : (i_cmd.push_held ? r_byte : w_hbyte);
        w_rem_new  = w_payload ? r_rem - LENGTH_BITS'(1) : r_rem;
        w_acc_new  = r_acc | ({56'd0, w_pbyte} << (6'd56 - {r_fill, 3'b000}));
        w_fill_new = {1'b0, r_fill} + 4'd1;
        w_off_new  = r_off + 8'd1;
        w_pend     = (w_off_new == tsp_pkg::TS_SIZE);
        w_emit     = w_pend || (w_fill_new == tsp_pkg::WORD_BYTES);
        w_last     = (w_rem_new == '0);
    end

    assign o_status.in_frame    = r_in_frame;
    assign o_status.offset_zero = (r_off == 8'd0);
    assign o_status.hdr_last    = (r_hidx == r_hend);
    assign o_status.can_push    = !o_out_valid || i_out_ready;

    // Control registers and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= tsp_pkg::DEFAULT_DELAY;
            r_in_frame  <= 1'b0;
            r_first     <= 1'b0;
            r_off       <= 8'd0;
            r_fill      <= 3'd0;
            r_rem       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_delay <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_rem      <= i_payload_length;
                r_in_frame <= (i_payload_length != '0);
                r_first    <= 1'b1;
                r_off      <= 8'd0;
                r_fill     <= 3'd0;
            end
            if (i_cmd.setup) begin
                r_first <= 1'b0;
            end
            if (w_push) begin
                r_rem  <= w_rem_new;
                r_fill <= w_emit ? 3'd0 : w_fill_new[2:0];
                r_off  <= w_pend ? 8'd0 : w_off_new;
                if (w_pend && w_last) begin
                    r_in_frame <= 1'b0;
                end
            end
            if (w_push && w_emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Frame fields, header setup and packed words.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pid <= i_pid;
            r_sid <= i_stream_id;
            r_pts <= i_pts;
            r_dts <= i_dts;
            r_key <= i_key_frame;
            r_cc  <= i_continuity_start;
            r_acc <= 64'd0;
        end
        if (i_cmd.latch) begin
            r_byte <= i_payload_byte;
        end
        if (i_cmd.setup) begin
            r_cc     <= r_cc + 4'd1;
            r_hidx   <= 8'd0;
            r_aend   <= w_aend;
            r_hend   <= w_hend;
            r_stuff  <= w_stuff;
            r_hfirst <= r_first;
            r_hadapt <= w_adapt;
            r_two    <= w_two;
            r_plen   <= (w_plen > PW'(tsp_pkg::PES_LEN_MAX)) ? 16'd0 : w_plen[15:0];
            r_pcr    <= r_dts - r_delay;
            r_spts   <= r_pts + r_delay;
            r_sdts   <= r_dts + r_delay;
        end
        if (i_cmd.push_hdr) begin
            r_hidx <= r_hidx + 8'd1;
        end
        if (w_push) begin
            r_acc <= w_emit ? 64'd0 : w_acc_new;
        end
        if (w_push && w_emit) begin
            o_data_word  <= w_acc_new;
            o_byte_count <= w_fill_new;
            o_packet_end <= w_pend;
            o_frame_end  <= w_pend && w_last;
            o_continuity <= r_cc;
        end
    end

endmodule

// File: test/ts_pes_packetizer_top_test.sv
// ----------------------------------------------------------------------------
// ts_pes_packetizer_top_test
// Self-checking bench for the TS packetizer: a software packet builder
// predicts every output word from the items sent in, and a checker compares
// each accepted word field by field in order.
// ----------------------------------------------------------------------------
module ts_pes_packetizer_top_test;

    localparam int LB = 24;
    localparam int DW = ((100 + LB + 7) / 8) * 8;
    localparam int QUIET_LIMIT = 20000;
    localparam logic [32:0] MASK33 = {33{1'b1}};

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        pkt_end;
        logic        frm_end;
        logic [3:0]  cc;
    } t_word;

    logic          i_clk, i_rst_n;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [32:0]   i_cfg_data;
    logic          s_tvalid, s_tready;
    logic [DW-1:0] s_tdata;
    logic [0:0]    s_tuser;
    logic          m_tvalid, m_tready;
    logic [71:0]   m_tdata;
    logic          m_tlast;
    logic [0:0]    m_tuser;

    ts_pes_packetizer_top #(.LENGTH_BITS(LB)) dut (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Predictor state: copy of the packetizer's frame and packing state.
    logic [32:0] delay_q;
    logic        pf_active, pf_first, pf_key;
    logic [23:0] pf_left;
    logic [3:0]  pf_cc;
    logic [7:0]  pf_off;
    logic [12:0] pf_pid;
    logic [7:0]  pf_sid;
    logic [32:0] pf_pts, pf_dts;
    logic [63:0] pk_acc;
    int          pk_fill;

    t_word expected_words[$];
    int    errors = 0;
    int    words_seen = 0;
    int    frames_sent = 0;
    int    send_idle_pct = 0, recv_idle_pct = 0;
    int    quiet = 0;

    function automatic void emit_word(int cnt, logic pe, logic fe);
        t_word w;
        w.word = pk_acc; w.nbytes = cnt[3:0]; w.pkt_end = pe; w.frm_end = fe;
        w.cc = pf_cc;
        expected_words.push_back(w);
        pk_acc = '0; pk_fill = 0;
    endfunction

    function automatic void pack_byte(logic [7:0] b);
        pk_acc |= 64'(b) << (56 - 8 * pk_fill);
        pk_fill++;
        pf_off++;
        if (pk_fill == 8) emit_word(8, 1'b0, 1'b0);
        if (pf_off >= tsp_pkg::TS_SIZE) begin
            emit_word(pk_fill, 1'b1, pf_left == 0);
            pf_off = 0;
            if (pf_left == 0) pf_active = 1'b0;
        end
    endfunction

    function automatic void pack_stamp(logic [3:0] prefix, logic [32:0] t);
        pack_byte({prefix, t[32:30], 1'b1});
        pack_byte(t[29:22]);
        pack_byte({t[21:15], 1'b1});
        pack_byte(t[14:7]);
        pack_byte({t[6:0], 1'b1});
    endfunction

    // Builds the TS header, the adaptation field when there is one and, on a first packet, the PES header.
    function automatic void pack_header();
        logic        adapt, two;
        int          hsize, hlen, body, stuff;
        logic [32:0] pcr;
        int unsigned plen;
        adapt = pf_first && pf_key;
        two = pf_dts != pf_pts;
        hsize = two ? 10 : 5;
        hlen = 4 + (adapt ? 8 : 0) + (pf_first ? 9 + hsize : 0);
        body = 188 - hlen;
        stuff = (pf_left < body) ? body - int'(pf_left) : 0;
        pf_cc = pf_cc + 4'd1;
        pack_byte(tsp_pkg::TS_SYNC);
        pack_byte({pf_first ? 3'b010 : 3'b000, pf_pid[12:8]});
        pack_byte(pf_pid[7:0]);
        pack_byte({2'b00, (adapt || stuff > 0), 1'b1, pf_cc});
        if (adapt) begin
            pcr = (pf_dts - delay_q) & MASK33;
            pack_byte(8'(7 + stuff));
            pack_byte(tsp_pkg::AF_FLAGS_PCR);
            pack_byte(pcr[32:25]);
            pack_byte(pcr[24:17]);
            pack_byte(pcr[16:9]);
            pack_byte(pcr[8:1]);
            pack_byte({pcr[0], tsp_pkg::PCR_EXT_LOW[6:0]});
            pack_byte(8'h00);
            for (int i = 0; i < stuff; i++) pack_byte(tsp_pkg::STUFF_BYTE);
        end else if (stuff > 0) begin
            pack_byte(8'(stuff - 1));
            if (stuff >= 2) begin
                pack_byte(8'h00);
                for (int i = 0; i < stuff - 2; i++) pack_byte(tsp_pkg::STUFF_BYTE);
            end
        end
        if (pf_first) begin
            plen = pf_left + hsize + 3;
            if (plen > 32'hFFFF) plen = 0;
            pack_byte(8'h00); pack_byte(8'h00); pack_byte(8'h01);
            pack_byte(pf_sid);
            pack_byte(plen[15:8]); pack_byte(plen[7:0]);
            pack_byte(tsp_pkg::PES_MARKER);
            pack_byte(two ? tsp_pkg::PES_PTS_DTS : tsp_pkg::PES_MARKER);
            pack_byte(8'(hsize));
            pack_stamp(two ? tsp_pkg::STAMP_BOTH : tsp_pkg::STAMP_PTS, pf_pts + delay_q);
            if (two) pack_stamp(tsp_pkg::STAMP_DTS, pf_dts + delay_q);
            pf_first = 1'b0;
        end
    endfunction

    function automatic void predict_frame_start(logic [12:0] pid, logic [7:0] sid,
            logic [32:0] pts, logic [32:0] dts, logic key, logic [23:0] len,
            logic [3:0] cc);
        pf_pid = pid; pf_sid = sid; pf_pts = pts; pf_dts = dts; pf_key = key;
        pf_left = len; pf_cc = cc; pf_first = 1'b1; pf_off = 0;
        pk_acc = '0; pk_fill = 0; pf_active = len != 0;
    endfunction

    function automatic void predict_payload(logic [7:0] b);
        if (!pf_active) return;
        if (pf_off == 0) pack_header();
        pf_left = pf_left - 24'd1;
        pack_byte(b);
    endfunction

    // Sends one item with a random leading gap at the current sender rate.
    // Valid stays high after the item so that a following item can go out
    // back to back; the idle gap or the drain wait lowers it.
    task automatic send_item(logic cmd, logic [DW-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1; s_tdata <= data; s_tuser <= cmd;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (cmd == tsp_pkg::CMD_START)
            predict_frame_start(data[20:8], data[28:21], data[61:29], data[94:62],
                                data[95], data[119:96], data[123:120]);
        else
            predict_payload(data[7:0]);
        @(negedge i_clk);
    endtask

    task automatic send_start(logic [12:0] pid, logic [7:0] sid, logic [32:0] pts,
            logic [32:0] dts, logic key, logic [23:0] len, logic [3:0] cc);
        logic [DW-1:0] d;
        d = '0;
        d[7:0] = 8'($urandom);
        d[20:8] = pid; d[28:21] = sid; d[61:29] = pts; d[94:62] = dts;
        d[95] = key; d[119:96] = len; d[123:120] = cc;
        send_item(tsp_pkg::CMD_START, d);
        frames_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        logic [DW-1:0] d;
        d = {DW{1'b0}};
        d[123:8] = 116'({$urandom, $urandom, $urandom, $urandom});
        d[7:0] = b;
        send_item(tsp_pkg::CMD_BYTE, d);
    endtask

    task automatic send_frame(int len, logic key, logic same_ts, int bytes_sent);
        logic [32:0] pts;
        pts = 33'({$urandom, $urandom});
        send_start(13'($urandom), 8'($urandom), pts,
                   same_ts ? pts : 33'({$urandom, $urandom}),
                   key, 24'(len), 4'($urandom));
        for (int i = 0; i < bytes_sent; i++) send_byte(8'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_delay(logic [32:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1; i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        delay_q = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Directed: field extremes, key/non-key, equal and distinct stamps,
    // empty frame, byte while idle, and a start that cuts a frame short.
    task automatic test_directed();
        send_byte(8'hFF);
        send_start(13'h1FFF, 8'hFF, MASK33, 33'd0, 1'b1, 24'd3, 4'hF);
        repeat (3) send_byte(8'hA5);
        send_start(13'd0, 8'h00, 33'd0, 33'd0, 1'b0, 24'd0, 4'd0);
        send_byte(8'h00);
        send_start(13'h0AA, 8'hE0, 33'd5, 33'd5, 1'b0, 24'hFFFFFF, 4'd7);
        repeat (4) send_byte(8'h5A);
        send_start(13'h155, 8'hC0, 33'd9, 33'd9, 1'b0, 24'd1, 4'd2);
        send_byte(8'h81);
    endtask

    // Random frames, mostly complete, with sizes kept within the item budget.
    task automatic test_random(int n_items);
        int sent, len, cut;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0: len = 0;
                1, 2: len = $urandom_range(150, 200);
                3: len = 0;
                default: len = $urandom_range(1, 40);
            endcase
            if ($urandom_range(9) == 0) len = $urandom_range(300, 400);
            if (len > n_items - sent) len = n_items - sent;
            cut = ($urandom_range(9) == 0 && len > 1) ? $urandom_range(len - 1) : len;
            send_frame(len, 1'($urandom_range(1)), 1'($urandom_range(1)), cut);
            if ($urandom_range(19) == 0) send_byte(8'($urandom));
            sent += cut + 1;
        end
    endtask

    // Delay register extremes; the middle frame spans two packets.
    task automatic test_delay_settings();
        write_delay(33'd0);
        send_frame(10, 1'b1, 1'b0, 10);
        write_delay(MASK33);
        send_frame(180, 1'b1, 1'b0, 180);
        write_delay(33'({$urandom, $urandom}));
        send_frame(8, 1'b1, 1'b1, 8);
        write_delay(tsp_pkg::DEFAULT_DELAY);
    endtask

    // Output checker.
    always @(posedge i_clk) begin
        t_word got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[63:0], m_tdata[67:64], m_tlast, m_tuser[0], m_tdata[71:68]};
            words_seen++;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch exp word=%h n=%0d pe=%b fe=%b cc=%0d", $time,
                             want.word, want.nbytes, want.pkt_end, want.frm_end, want.cc);
                    $display("%0t:          act word=%h n=%0d pe=%b fe=%b cc=%0d", $time,
                             got.word, got.nbytes, got.pkt_end, got.frm_end, got.cc);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern.
    always @(negedge i_clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || expected_words.size() == 0
            && !s_tvalid)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("FAIL ts_pes_packetizer_top");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        delay_q = tsp_pkg::DEFAULT_DELAY;
        predict_frame_start('0, '0, '0, '0, 1'b0, '0, '0);
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        send_idle_pct = 38; recv_idle_pct = 85;
        test_directed();
        test_delay_settings();
        test_random(35);
        wait_drained();
        send_idle_pct = 85; recv_idle_pct = 38;
        test_random(35);
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(35);
        wait_drained();
        $display("Covered %0d frames in three idle patterns and four delay settings;",
                 frames_sent);
        $display("%0d output words checked.", words_seen);
        if (errors == 0)
            $display("PASS ts_pes_packetizer_top");
        else
            $display("FAIL ts_pes_packetizer_top");
        $finish;
    end
endmodule

// File: filelist.f
sv/tsp_pkg.sv
sv/tsp_ctrl.sv
sv/tsp_datapath.sv
sv/ts_pes_packetizer_top.sv
test/ts_pes_packetizer_top_test.sv
